// ===== rtl/qoi_pkg.sv =====
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types and constants for the chunk stream decoder.
// ----------------------------------------------------------------------------
package qoi_pkg;

   // chunk tags
   localparam logic [7:0] TAG_RGB  = 8'hFE;
   localparam logic [7:0] TAG_RGBA = 8'hFF;
   localparam logic [1:0] TAG2_INDEX = 2'b00;
   localparam logic [1:0] TAG2_DIFF  = 2'b01;
   localparam logic [1:0] TAG2_LUMA  = 2'b10;

   // previous pixel after a restart: r g b zero, alpha full
   localparam logic [31:0] PIX_RESET = 32'h0000_00FF;

   // longest run a single chunk carries
   localparam int unsigned RUN_MAX = 62;

   // configuration register indexes
   localparam logic CSR_PIXEL_TOTAL   = 1'b0;
   localparam logic CSR_CHANNEL_COUNT = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_PIXEL    = 2'd0;
   localparam logic [1:0] KIND_MATCH    = 2'd1;
   localparam logic [1:0] KIND_MISMATCH = 2'd2;

   // where the stream stands
   typedef enum logic [1:0] {
      PH_CHUNKS   = 2'd0,
      PH_MARK_OK  = 2'd1,
      PH_MARK_BAD = 2'd2,
      PH_DONE     = 2'd3
   } phase_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_FINISH = 2'd1,
      S_EMIT   = 2'd2,
      S_MARK   = 2'd3
   } state_type;

endpackage

// ===== rtl/qoi_ram.sv =====
// ----------------------------------------------------------------------------
// qoi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module qoi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/qoi_chunk_decoder_core.sv =====
// ----------------------------------------------------------------------------
// qoi_chunk_decoder_core
// Byte-serial decoder for the QOI chunk stream with end marker check.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one stream byte per word (after the file header); set
//   req_frame_start on the first byte of an image to restart the decoder.
//   rsp_* carries one result per word: a decoded pixel, or after
//   pixel_total pixels one end marker verdict (matched or mismatched).
//   csr_* writes pixel_total (index 0) and channel_count (index 1) while idle.
// Sequence:
//   a byte that only completes part of a chunk or marker keeps state idle.
//   a chunk's last byte starts the table read; a finish state then decodes
//   and writes the table (the registered RAM read sets this state), and an
//   emit state sends the pixels one by one; req_ready stays low until a run
//   is out. The last marker byte moves to a mark state for the verdict.
//   results sit in an output register; a new byte is taken while the last
//   result waits, and emission pauses while rsp_ready is low.
// Reset:
//   synchronous; clears the sequencer, the previous pixel (0,0,0,255), the
//   table valid bits (table reads as zero), pixel_total and the output valid.
// ----------------------------------------------------------------------------
module qoi_chunk_decoder_core #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_frame_start,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_run_last,
   output logic        rsp_image_last,
   // configuration
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [24:0] csr_write_data
);

   localparam int ADDR_W = $clog2(TABLE_ENTRIES);

   // registers
   qoi_pkg::state_type          state_ff, state_in;
   qoi_pkg::phase_type          phase_ff, phase_in;
   logic [2:0]                  pend_ff, pend_in;
   logic [24:0]                 done_ff, done_in;
   logic [3:0]                  mpos_ff, mpos_in;
   logic [7:0]                  op_ff, op_in;
   logic [31:0]                 cb_ff, cb_in;
   logic [31:0]                 prior_ff, prior_in;
   logic [24:0]                 total_ff;
   logic [TABLE_ENTRIES-1:0]    valid_ff, valid_in;
   logic                        idx_valid_ff, idx_valid_in;
   logic [31:0]                 px_ff, px_in;
   logic [5:0]                  cnt_ff, cnt_in;
   logic [1:0]                  kind_ff, kind_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_kind_ff, rsp_kind_in;
   logic [31:0]                 rsp_px_ff, rsp_px_in;
   logic                        rsp_run_last_ff, rsp_run_last_in;
   logic                        rsp_image_last_ff, rsp_image_last_in;

   // combinational
   logic               accept;
   logic               slot_free;
   qoi_pkg::phase_type e_phase, m_phase;
   logic [2:0]         e_pend;
   logic [24:0]        e_done;
   logic [3:0]         e_mpos;
   logic [31:0]        e_cb;
   logic [31:0]        e_prior;
   logic [7:0]         expect_byte;
   logic [31:0]        rd_data;
   logic [31:0]        tbl_px;
   logic [31:0]        dec_px;
   logic [6:0]         dec_count;
   logic [7:0]         pr, pg, pb, pa;
   logic [7:0]         luma_g;
   logic [11:0]        hash_sum;
   logic [ADDR_W-1:0]  hash_slot;
   logic [24:0]        remaining;
   logic [5:0]         emit_n;
   logic               tbl_we;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == qoi_pkg::S_IDLE);

   // color table
   qoi_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (hash_slot),
      .wr_data (dec_px),
      .rd_en   (accept),
      .rd_addr (req_stream_byte[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // state seen by the incoming byte, restart and end-of-pixels applied
   always_comb begin
      e_phase = req_frame_start ? qoi_pkg::PH_CHUNKS : phase_ff;
      e_pend  = req_frame_start ? 3'd0 : pend_ff;
      e_done  = req_frame_start ? 25'd0 : done_ff;
      e_mpos  = req_frame_start ? 4'd0 : mpos_ff;
      e_cb    = req_frame_start ? 32'd0 : cb_ff;
      e_prior = req_frame_start ? qoi_pkg::PIX_RESET : prior_ff;
      if (e_phase == qoi_pkg::PH_CHUNKS && e_pend == 3'd0 && e_done >= total_ff) begin
         e_phase = qoi_pkg::PH_MARK_OK;
         e_mpos  = 4'd0;
      end
      expect_byte = (e_mpos == 4'd7) ? 8'd1 : 8'd0;
      m_phase     = (req_stream_byte != expect_byte) ? qoi_pkg::PH_MARK_BAD : e_phase;
   end

   // chunk decode from the held opcode, payload, previous pixel and table read; hash slot and emit count
   always_comb begin
      pr = prior_ff[31:24];
      pg = prior_ff[23:16];
      pb = prior_ff[15:8];
      pa = prior_ff[7:0];
      tbl_px    = idx_valid_ff ? rd_data : 32'd0;
      luma_g    = pg + {2'b00, op_ff[5:0]} - 8'd32;
      dec_count = 7'd1;
      if (op_ff == qoi_pkg::TAG_RGB) begin
         dec_px = {cb_ff[23:0], pa};
      end else if (op_ff == qoi_pkg::TAG_RGBA) begin
         dec_px = cb_ff;
      end else begin
         unique case (op_ff[7:6])
            qoi_pkg::TAG2_INDEX: dec_px = tbl_px;
            qoi_pkg::TAG2_DIFF: begin
               dec_px = {pr + {6'd0, op_ff[5:4]} - 8'd2,
                         pg + {6'd0, op_ff[3:2]} - 8'd2,
                         pb + {6'd0, op_ff[1:0]} - 8'd2, pa};
            end
            qoi_pkg::TAG2_LUMA: begin
               dec_px = {pr + {2'b00, op_ff[5:0]} + {4'd0, cb_ff[7:4]} - 8'd40,
                         luma_g,
                         pb + {2'b00, op_ff[5:0]} + {4'd0, cb_ff[3:0]} - 8'd40, pa};
            end
            default: begin
               dec_px    = prior_ff;
               dec_count = {1'b0, op_ff[5:0]} + 7'd1;
            end
         endcase
      end
      hash_sum = 12'(dec_px[31:24]) * 12'd3 + 12'(dec_px[23:16]) * 12'd5
               + 12'(dec_px[15:8]) * 12'd7 + 12'(dec_px[7:0]) * 12'd11;
      hash_slot = hash_sum[ADDR_W-1:0];
      remaining = (done_ff < total_ff) ? (total_ff - done_ff) : 25'd0;
      emit_n    = (remaining < 25'(dec_count)) ? remaining[5:0] : dec_count[5:0];
   end

   assign tbl_we = (state_ff == qoi_pkg::S_FINISH);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qoi_pkg::S_IDLE: begin
            if (accept) begin
               if (e_phase == qoi_pkg::PH_MARK_OK || e_phase == qoi_pkg::PH_MARK_BAD) begin
                  if (e_mpos == 4'd7) state_in = qoi_pkg::S_MARK;
               end else if (e_phase == qoi_pkg::PH_CHUNKS) begin
                  if (e_pend == 3'd1) begin
                     state_in = qoi_pkg::S_FINISH;
                  end else if (e_pend == 3'd0 && req_stream_byte != qoi_pkg::TAG_RGB
                               && req_stream_byte != qoi_pkg::TAG_RGBA
                               && req_stream_byte[7:6] != qoi_pkg::TAG2_LUMA) begin
                     state_in = qoi_pkg::S_FINISH;
                  end
               end
            end
         end
         qoi_pkg::S_FINISH: state_in = (emit_n == 6'd0) ? qoi_pkg::S_IDLE : qoi_pkg::S_EMIT;
         qoi_pkg::S_EMIT: begin
            if (slot_free && cnt_ff == 6'd1) state_in = qoi_pkg::S_IDLE;
         end
         qoi_pkg::S_MARK: begin
            if (slot_free) state_in = qoi_pkg::S_IDLE;
         end
         default: state_in = qoi_pkg::S_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      phase_in          = phase_ff;
      pend_in           = pend_ff;
      done_in           = done_ff;
      mpos_in           = mpos_ff;
      op_in             = op_ff;
      cb_in             = cb_ff;
      prior_in          = prior_ff;
      valid_in          = valid_ff;
      idx_valid_in      = idx_valid_ff;
      px_in             = px_ff;
      cnt_in            = cnt_ff;
      kind_in           = kind_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_kind_in       = rsp_kind_ff;
      rsp_px_in         = rsp_px_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_image_last_in = rsp_image_last_ff;
      unique case (state_ff)
         qoi_pkg::S_IDLE: begin
            if (accept) begin
               phase_in     = e_phase;
               pend_in      = e_pend;
               done_in      = e_done;
               mpos_in      = e_mpos;
               cb_in        = e_cb;
               prior_in     = e_prior;
               idx_valid_in = !req_frame_start && valid_ff[req_stream_byte[ADDR_W-1:0]];
               if (req_frame_start) valid_in = '0;
               unique case (e_phase)
                  qoi_pkg::PH_MARK_OK, qoi_pkg::PH_MARK_BAD: begin
                     mpos_in  = e_mpos + 4'd1;
                     phase_in = m_phase;
                     if (e_mpos == 4'd7) begin
                        kind_in  = (m_phase == qoi_pkg::PH_MARK_OK) ? qoi_pkg::KIND_MATCH
                                                                    : qoi_pkg::KIND_MISMATCH;
                        phase_in = qoi_pkg::PH_DONE;
                     end
                  end
                  qoi_pkg::PH_CHUNKS: begin
                     if (e_pend != 3'd0) begin
                        cb_in   = {e_cb[23:0], req_stream_byte};
                        pend_in = e_pend - 3'd1;
                     end else begin
                        op_in = req_stream_byte;
                        cb_in = 32'd0;
                        if (req_stream_byte == qoi_pkg::TAG_RGB) begin
                           pend_in = 3'd3;
                        end else if (req_stream_byte == qoi_pkg::TAG_RGBA) begin
                           pend_in = 3'd4;
                        end else if (req_stream_byte[7:6] == qoi_pkg::TAG2_LUMA) begin
                           pend_in = 3'd1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         qoi_pkg::S_FINISH: begin
            valid_in[hash_slot] = 1'b1;
            prior_in = dec_px;
            cb_in    = 32'd0;
            px_in    = dec_px;
            cnt_in   = emit_n;
         end
         qoi_pkg::S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = qoi_pkg::KIND_PIXEL;
               rsp_px_in         = px_ff;
               rsp_run_last_in   = (cnt_ff == 6'd1);
               rsp_image_last_in = (done_ff + 25'd1 == total_ff);
               done_in           = done_ff + 25'd1;
               cnt_in            = cnt_ff - 6'd1;
            end
         end
         qoi_pkg::S_MARK: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = kind_ff;
               rsp_px_in         = 32'd0;
               rsp_run_last_in   = 1'b1;
               rsp_image_last_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qoi_pkg::S_IDLE;
         phase_ff     <= qoi_pkg::PH_CHUNKS;
         pend_ff      <= 3'd0;
         done_ff      <= 25'd0;
         mpos_ff      <= 4'd0;
         op_ff        <= 8'd0;
         cb_ff        <= 32'd0;
         prior_ff     <= qoi_pkg::PIX_RESET;
         valid_ff     <= '0;
         cnt_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         mpos_ff      <= mpos_in;
         op_ff        <= op_in;
         cb_ff        <= cb_in;
         prior_ff     <= prior_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration; channel count only informs the consumer and is not kept
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 25'd0;
      end else if (csr_write_enable && csr_index == qoi_pkg::CSR_PIXEL_TOTAL) begin
         total_ff <= csr_write_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_valid_ff      <= idx_valid_in;
      px_ff             <= px_in;
      kind_ff           <= kind_in;
      rsp_kind_ff       <= rsp_kind_in;
      rsp_px_ff         <= rsp_px_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_image_last_ff <= rsp_image_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_red         = rsp_px_ff[31:24];
   assign rsp_green       = rsp_px_ff[23:16];
   assign rsp_blue        = rsp_px_ff[15:8];
   assign rsp_alpha       = rsp_px_ff[7:0];
   assign rsp_run_last    = rsp_run_last_ff;
   assign rsp_image_last  = rsp_image_last_ff;

   // emission never starts with an empty count
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == qoi_pkg::S_EMIT |-> cnt_ff != 6'd0)
      else $error("emit state with zero count");

   // marker verdicts always carry run_last set and image_last clear
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != qoi_pkg::KIND_PIXEL |-> rsp_run_last_ff && !rsp_image_last_ff)
      else $error("marker result with wrong flags");

   // table written only on the cycle after a chunk byte was taken
   a_finish_follows_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == qoi_pkg::S_FINISH |-> $past(accept))
      else $error("decode without an accepted byte");

endmodule
